### hw/rtl/eacsr_pkg.sv
// shared types and constants for the element adjacency builder
package eacsr_pkg;

	localparam int MAX_NODES_DEF         = 32;
	localparam int MAX_ELEMENT_NODES_DEF = 8;

	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam logic [0:0] CFG_NODE_COUNT   = 1'd0;
	localparam logic [0:0] CFG_ELEMENT_SIZE = 1'd1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_MARK,
		S_SUM,
		S_LEN,
		S_EMIT,
		S_QUERY,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       take;       // latch input item
		logic       clr_start;  // start clearing sweep
		logic       clr_step;
		logic       set_err;
		logic       clr_err;
		logic       push;       // store node into element
		logic       fill_clr;
		logic       mark_start; // begin pair marking
		logic       mark_step;
		logic       sum_start;  // begin prefix sum
		logic       sum_step;
		logic       len_load;   // load row bits
		logic       emit_step;  // advance to next neighbour
		logic       query_load;
		logic       out_load;   // load simple result
		logic [1:0] out_status;
		logic       out_valid_set;
		logic       emit_load;  // load neighbour result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic action_push;
		logic action_read;
		logic action_query;
		logic action_clear;
		logic err;
		logic nid_bad;
		logic row_bad;
		logic col_bad;
		logic elem_done;   // element complete after this push
		logic clr_done;
		logic mark_done;
		logic sum_done;
		logic row_empty;
		logic emit_last;
		logic out_busy;    // output register full and not leaving
	} sts_t;

endpackage

### hw/rtl/eacsr_ctrl.sv
// controller state machine of the element adjacency builder
module eacsr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output eacsr_pkg::cmd_t   cmd,
	input  eacsr_pkg::sts_t   sts
);

	eacsr_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= eacsr_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			eacsr_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = eacsr_pkg::S_OUT;
				end
			end
			eacsr_pkg::S_OUT: begin
				// dispatch latched item
				if (sts.action_clear) begin
					cmd.clr_start = 1'b1;
					cmd.clr_err   = 1'b1;
					cmd.fill_clr  = 1'b1;
					state_d       = eacsr_pkg::S_CLEAR;
				end else if (sts.err) begin
					if (!sts.out_busy) begin
						cmd.out_load   = 1'b1;
						cmd.out_status = eacsr_pkg::ST_INVALID;
						state_d        = eacsr_pkg::S_IDLE;
					end
				end else if (sts.action_push) begin
					if (sts.nid_bad) begin
						cmd.clr_start = 1'b1;
						cmd.set_err   = 1'b1;
						cmd.fill_clr  = 1'b1;
						state_d       = eacsr_pkg::S_CLEAR;
					end else begin
						cmd.push = 1'b1;
						if (sts.elem_done) begin
							cmd.mark_start = 1'b1;
							state_d        = eacsr_pkg::S_MARK;
						end else begin
							state_d = eacsr_pkg::S_EMIT;
						end
					end
				end else if (sts.action_query) begin
					if (sts.row_bad || sts.col_bad) begin
						state_d = eacsr_pkg::S_EMIT;
					end else begin
						state_d = eacsr_pkg::S_QUERY;
					end
				end else begin
					if (sts.row_bad) begin
						state_d = eacsr_pkg::S_EMIT;
					end else begin
						cmd.sum_start = 1'b1;
						state_d       = eacsr_pkg::S_SUM;
					end
				end
			end
			eacsr_pkg::S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = eacsr_pkg::S_EMIT;
			end
			eacsr_pkg::S_MARK: begin
				cmd.mark_step = 1'b1;
				if (sts.mark_done) begin
					cmd.fill_clr = 1'b1;
					state_d      = eacsr_pkg::S_EMIT;
				end
			end
			eacsr_pkg::S_SUM: begin
				cmd.sum_step = 1'b1;
				if (sts.sum_done) state_d = eacsr_pkg::S_LEN;
			end
			eacsr_pkg::S_LEN: begin
				cmd.len_load = 1'b1;
				state_d      = eacsr_pkg::S_EMIT;
			end
			eacsr_pkg::S_QUERY: begin
				cmd.query_load = 1'b1;
				state_d        = eacsr_pkg::S_EMIT;
			end
			eacsr_pkg::S_EMIT: begin
				// produce results one per free output slot
				if (!sts.out_busy) begin
					if (sts.action_read && !sts.row_bad && !sts.row_empty) begin
						cmd.emit_load = 1'b1;
						cmd.emit_step = 1'b1;
						if (sts.emit_last) state_d = eacsr_pkg::S_IDLE;
					end else begin
						cmd.out_load = 1'b1;
						if (sts.action_clear) cmd.out_status = eacsr_pkg::ST_OK;
						else if (sts.action_push && sts.nid_bad)
							cmd.out_status = eacsr_pkg::ST_RANGE;
						else if (sts.row_bad && !sts.action_push) cmd.out_status = eacsr_pkg::ST_RANGE;
						else if (sts.action_query && sts.col_bad)
							cmd.out_status = eacsr_pkg::ST_RANGE;
						else cmd.out_status = eacsr_pkg::ST_OK;
						state_d = eacsr_pkg::S_IDLE;
					end
				end
			end
			default: state_d = eacsr_pkg::S_IDLE;
		endcase
		cmd.out_valid_set = cmd.out_load | cmd.emit_load;
	end

endmodule

### hw/rtl/eacsr_dp.sv
// datapath of the element adjacency builder: matrix, element buffer, counters
module eacsr_dp #(
	parameter int MAX_ELEMENT_NODES = eacsr_pkg::MAX_ELEMENT_NODES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_write,
	input  logic [0:0]      cfg_index,
	input  logic [5:0]      cfg_data,
	input  logic [1:0]      action,
	input  logic [4:0]      node_id,
	input  logic [4:0]      query_row,
	input  logic [4:0]      query_column,
	input  eacsr_pkg::cmd_t cmd,
	output eacsr_pkg::sts_t sts,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      status,
	output logic [4:0]      neighbour,
	output logic [9:0]      item_position,
	output logic [9:0]      row_start,
	output logic [4:0]      row_length,
	output logic            linked,
	output logic            last
);

	localparam int MAX_NODES = eacsr_pkg::MAX_NODES_DEF;
	localparam int RW = $clog2(MAX_NODES);
	localparam int EW = $clog2(MAX_ELEMENT_NODES);
	localparam int FW = $clog2(MAX_ELEMENT_NODES + 1);
	localparam int CW = $clog2(MAX_NODES + 1);

	logic [5:0]  node_count_q;
	logic [3:0]  element_size_q;
	logic [1:0]  action_q;
	logic [4:0]  nid_q, row_q, col_q;
	logic        err_q;
	logic [FW-1:0] fill_q;
	logic [4:0]  elem_q [MAX_ELEMENT_NODES];
	logic [MAX_NODES-1:0] adj_q [MAX_NODES];
	logic [RW:0] sweep_q;
	logic [EW:0] mi_q;
	logic [9:0]  start_q;
	logic [MAX_NODES-1:0] bits_q;
	logic [4:0]  len_q;
	logic [4:0]  rank_q;
	logic        hit_q;

	// effective configuration
	logic [6:0]  eff_n;
	logic [FW-1:0] eff_size;
	logic [MAX_NODES-1:0] mask;
	always_comb begin
		eff_n = (7'(node_count_q) > 7'(MAX_NODES)) ? 7'(MAX_NODES) : 7'(node_count_q);
		if (element_size_q == 4'd0) eff_size = FW'(1);
		else if (32'(element_size_q) > MAX_ELEMENT_NODES) eff_size = FW'(MAX_ELEMENT_NODES);
		else eff_size = FW'(element_size_q);
		for (int c = 0; c < MAX_NODES; c++) mask[c] = (7'(c) < eff_n);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q   <= 6'd32;
			element_size_q <= 4'd4;
		end else if (cfg_write) begin
			case (cfg_index)
				eacsr_pkg::CFG_NODE_COUNT:   node_count_q   <= cfg_data;
				eacsr_pkg::CFG_ELEMENT_SIZE: element_size_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// latched input item
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			action_q <= action;
			nid_q    <= node_id;
			row_q    <= query_row;
			col_q    <= query_column;
		end
	end

	// sticky error and element fill
	logic [FW-1:0] fill_next;
	assign fill_next = (32'(fill_q) < MAX_ELEMENT_NODES) ? fill_q + FW'(1) : fill_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q  <= 1'b0;
			fill_q <= '0;
		end else begin
			if (cmd.set_err) err_q <= 1'b1;
			else if (cmd.clr_err) err_q <= 1'b0;
			if (cmd.fill_clr) fill_q <= '0;
			else if (cmd.push) fill_q <= fill_next;
		end
	end

	// element node buffer
	always_ff @(posedge clk) begin
		if (cmd.push && 32'(fill_q) < MAX_ELEMENT_NODES) elem_q[fill_q[EW-1:0]] <= nid_q;
	end

	// pair marking: one element node a cycle ors its row with all others
	logic [MAX_NODES-1:0] elem_row;
	logic [4:0]           mark_a;
	always_comb begin
		mark_a   = elem_q[mi_q[EW-1:0]];
		elem_row = '0;
		for (int j = 0; j < MAX_ELEMENT_NODES; j++) begin
			if (32'(j) < 32'(fill_q)) elem_row[RW'(elem_q[j])] = 1'b1;
		end
		elem_row[RW'(mark_a)] = 1'b0;
	end

	// matrix: clear sweep and marking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_NODES; r++) adj_q[r] <= '0;
		end else if (cmd.clr_step && !sweep_q[RW]) begin
			adj_q[sweep_q[RW-1:0]] <= '0;
		end else if (cmd.mark_step && 32'(mi_q) < 32'(fill_q)) begin
			adj_q[RW'(mark_a)] <= adj_q[RW'(mark_a)] | elem_row;
		end
	end

	// sweep, marking and sum counters
	logic [CW-1:0] pc;
	assign pc = CW'($countones(adj_q[sweep_q[RW-1:0]] & mask));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			mi_q    <= '0;
			start_q <= '0;
		end else begin
			if (cmd.clr_start || cmd.sum_start) sweep_q <= '0;
			else if (cmd.clr_step || cmd.sum_step) sweep_q <= sweep_q + (RW+1)'(1);
			if (cmd.mark_start) mi_q <= '0;
			else if (cmd.mark_step) mi_q <= mi_q + (EW+1)'(1);
			if (cmd.sum_start) start_q <= '0;
			else if (cmd.sum_step && 32'(sweep_q) < 32'(row_q))
				start_q <= start_q + 10'(pc);
		end
	end

	// row bits, neighbour scan, query bit
	logic [4:0] first_c;
	always_comb begin
		first_c = '0;
		for (int c = MAX_NODES - 1; c >= 0; c--) if (bits_q[c]) first_c = 5'(c);
	end
	always_ff @(posedge clk) begin
		if (cmd.len_load) begin
			bits_q <= adj_q[RW'(row_q)] & mask;
			len_q  <= 5'($countones(adj_q[RW'(row_q)] & mask));
			rank_q <= '0;
		end else if (cmd.emit_step) begin
			bits_q[RW'(first_c)] <= 1'b0;
			rank_q <= rank_q + 5'd1;
		end
		if (cmd.query_load) hit_q <= adj_q[RW'(row_q)][RW'(col_q)];
	end

	// status to controller
	always_comb begin
		sts              = '0;
		sts.action_push  = (action_q == eacsr_pkg::ACT_PUSH);
		sts.action_read  = (action_q == eacsr_pkg::ACT_READ);
		sts.action_query = (action_q == eacsr_pkg::ACT_QUERY);
		sts.action_clear = (action_q == eacsr_pkg::ACT_CLEAR);
		sts.err          = err_q;
		sts.nid_bad      = (7'(nid_q) >= eff_n);
		sts.row_bad      = (7'(row_q) >= eff_n);
		sts.col_bad      = (7'(col_q) >= eff_n);
		sts.elem_done    = (fill_next >= eff_size);
		sts.clr_done     = sweep_q[RW] || (32'(sweep_q) == MAX_NODES - 1);
		sts.mark_done    = (32'(mi_q) + 1 >= 32'(fill_q));
		sts.sum_done     = (32'(sweep_q) + 1 >= 32'(row_q)) || (row_q == 5'd0);
		sts.row_empty    = (len_q == 5'd0);
		sts.emit_last    = (rank_q + 5'd1 == len_q);
		sts.out_busy     = out_valid && out_stall;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.out_valid_set) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			status        <= eacsr_pkg::ST_OK;
			neighbour     <= first_c;
			item_position <= start_q + 10'(rank_q);
			row_start     <= start_q;
			row_length    <= len_q;
			linked        <= 1'b0;
			last          <= sts.emit_last;
		end else if (cmd.out_load) begin
			status        <= cmd.out_status;
			neighbour     <= '0;
			item_position <= '0;
			row_start     <= (sts.action_read && cmd.out_status == eacsr_pkg::ST_OK
				&& !err_q) ? start_q : '0;
			row_length    <= '0;
			linked        <= sts.action_query && cmd.out_status == eacsr_pkg::ST_OK
				&& !err_q && hit_q;
			last          <= 1'b1;
		end
	end

endmodule

### hw/rtl/element_adjacency_csr_builder_top.sv
// top level of the element adjacency builder
// Items are taken one at a time. A push stores its node and, when it
// completes an element, marks the element's pairs (one element node marked
// per cycle); a clear or an out-of-range push runs the 32-row clearing
// sweep; a row read forms the prefix sum of earlier rows (one row popcount
// per cycle) and then emits one result per neighbour, or a single result
// for an empty row; a link query reads one matrix bit; a push, read or query
// while the error is sticky gives an invalid status. Each result sits in an
// output register, and emission waits while that register is stalled.
module element_adjacency_csr_builder_top #(
	parameter int MAX_ELEMENT_NODES = eacsr_pkg::MAX_ELEMENT_NODES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic [0:0] cfg_index,
	input  logic [5:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] action,
	input  logic [4:0] node_id,
	input  logic [4:0] query_row,
	input  logic [4:0] query_column,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [4:0] neighbour,
	output logic [9:0] item_position,
	output logic [9:0] row_start,
	output logic [4:0] row_length,
	output logic       linked,
	output logic       last
);

	eacsr_pkg::cmd_t cmd;
	eacsr_pkg::sts_t sts;

	// controller
	eacsr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .sts(sts)
	);

	// datapath
	eacsr_dp #(.MAX_ELEMENT_NODES(MAX_ELEMENT_NODES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .action(action), .node_id(node_id),
		.query_row(query_row), .query_column(query_column), .cmd(cmd), .sts(sts),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.neighbour(neighbour), .item_position(item_position), .row_start(row_start),
		.row_length(row_length), .linked(linked), .last(last)
	);

endmodule

### tb/sv/eacsr_checker.sv
// checker for the element adjacency builder: predicts results and compares transfers
`timescale 1ns / 1ps
module eacsr_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic [0:0] cfg_index,
	input  logic [5:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] action,
	input  logic [4:0] node_id,
	input  logic [4:0] query_row,
	input  logic [4:0] query_column,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [1:0] status,
	input  logic [4:0] neighbour,
	input  logic [9:0] item_position,
	input  logic [9:0] row_start,
	input  logic [4:0] row_length,
	input  logic       linked,
	input  logic       last,
	output int         fail_count,
	output int         pending
);

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] neighbour;
		logic [9:0] item_position;
		logic [9:0] row_start;
		logic [4:0] row_length;
		logic       linked;
		logic       last;
	} result_t;

	result_t     expected_results[$];
	logic [31:0] adj[32];
	logic [4:0]  held_nodes[8];
	int          held_fill;
	logic        graph_error;
	logic [5:0]  nodes_reg;
	logic [3:0]  size_reg;

	assign pending = expected_results.size();

	function automatic result_t simple_result(logic [1:0] st, logic hit);
		result_t r;
		r = '0;
		r.status = st;
		r.linked = hit;
		r.last = 1'b1;
		return r;
	endfunction

	// apply one accepted item to the mirror graph and queue its results
	task automatic predict_item(logic [1:0] act, logic [4:0] nid, logic [4:0] row,
			logic [4:0] col);
		int          n, sz, start, len, k;
		logic [31:0] mask, bits;
		result_t     r;
		n = (nodes_reg > 32) ? 32 : nodes_reg;
		sz = (size_reg == 0) ? 1 : ((size_reg > 8) ? 8 : size_reg);
		mask = (n >= 32) ? 32'hffffffff : ((32'd1 << n) - 1);
		if (act == eacsr_pkg::ACT_CLEAR) begin
			foreach (adj[i]) adj[i] = '0;
			held_fill = 0;
			graph_error = 1'b0;
			expected_results.push_back(simple_result(eacsr_pkg::ST_OK, 0));
		end else if (graph_error) begin
			expected_results.push_back(simple_result(eacsr_pkg::ST_INVALID, 0));
		end else if (act == eacsr_pkg::ACT_PUSH) begin
			if (nid >= n) begin
				foreach (adj[i]) adj[i] = '0;
				held_fill = 0;
				graph_error = 1'b1;
				expected_results.push_back(simple_result(eacsr_pkg::ST_RANGE, 0));
			end else begin
				if (held_fill < 8) begin
					held_nodes[held_fill] = nid;
					held_fill++;
				end
				if (held_fill >= sz) begin
					for (int i = 0; i < held_fill; i++)
						for (int j = 0; j < held_fill; j++)
							if (held_nodes[i] != held_nodes[j])
								adj[held_nodes[i]][held_nodes[j]] = 1'b1;
					held_fill = 0;
				end
				expected_results.push_back(simple_result(eacsr_pkg::ST_OK, 0));
			end
		end else if (act == eacsr_pkg::ACT_QUERY) begin
			if (row >= n || col >= n)
				expected_results.push_back(simple_result(eacsr_pkg::ST_RANGE, 0));
			else
				expected_results.push_back(simple_result(eacsr_pkg::ST_OK, adj[row][col]));
		end else begin
			if (row >= n) begin
				expected_results.push_back(simple_result(eacsr_pkg::ST_RANGE, 0));
			end else begin
				start = 0;
				for (int i = 0; i < row; i++) start += $countones(adj[i] & mask);
				bits = adj[row] & mask;
				len = $countones(bits);
				if (len == 0) begin
					r = simple_result(eacsr_pkg::ST_OK, 0);
					r.row_start = 10'(start);
					expected_results.push_back(r);
				end else begin
					k = 0;
					for (int c = 0; c < 32; c++) begin
						if (bits[c]) begin
							r = '0;
							r.neighbour = 5'(c);
							r.item_position = 10'(start + k);
							r.row_start = 10'(start);
							r.row_length = 5'(len);
							r.last = (k + 1 == len);
							expected_results.push_back(r);
							k++;
						end
					end
				end
			end
		end
	endtask

	// mirror state, predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			foreach (adj[i]) adj[i] = '0;
			held_fill = 0;
			graph_error = 1'b0;
			nodes_reg = 6'd32;
			size_reg = 4'd4;
			fail_count = 0;
			expected_results.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result transfer");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status) begin
						$error("status exp %0d got %0d", want.status, status);
						fail_count++;
					end
					if (neighbour !== want.neighbour) begin
						$error("neighbour exp %0d got %0d", want.neighbour, neighbour);
						fail_count++;
					end
					if (item_position !== want.item_position) begin
						$error("item_position exp %0d got %0d", want.item_position,
							item_position);
						fail_count++;
					end
					if (row_start !== want.row_start) begin
						$error("row_start exp %0d got %0d", want.row_start, row_start);
						fail_count++;
					end
					if (row_length !== want.row_length) begin
						$error("row_length exp %0d got %0d", want.row_length, row_length);
						fail_count++;
					end
					if (linked !== want.linked) begin
						$error("linked exp %0d got %0d", want.linked, linked);
						fail_count++;
					end
					if (last !== want.last) begin
						$error("last exp %0d got %0d", want.last, last);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				predict_item(action, node_id, query_row, query_column);
			if (cfg_write) begin
				if (cfg_index == eacsr_pkg::CFG_NODE_COUNT) nodes_reg = cfg_data;
				else size_reg = cfg_data[3:0];
			end
		end
	end
endmodule

### tb/sv/tb.sv
// testbench top for the element adjacency builder: stimulus and verdict
`timescale 1ns / 1ps
module tb;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       cfg_write = 0;
	logic [0:0] cfg_index = 0;
	logic [5:0] cfg_data = 0;
	logic       in_valid = 0;
	logic       in_stall;
	logic [1:0] action = 0;
	logic [4:0] node_id = 0;
	logic [4:0] query_row = 0;
	logic [4:0] query_column = 0;
	logic       out_valid;
	logic       out_stall = 0;
	logic [1:0] status;
	logic [4:0] neighbour;
	logic [9:0] item_position;
	logic [9:0] row_start;
	logic [4:0] row_length;
	logic       linked;
	logic       last;
	int         fail_count;
	int         pending;
	logic       calm = 0;

	always #1 clk = ~clk;

	element_adjacency_csr_builder_top dut (.*);
	eacsr_checker checker_i (.*);

	// receiver stalls at random except in calm stretches
	always @(negedge clk)
		out_stall <= !calm && ($urandom_range(99) < 19);

	// one input transfer, with a random gap before it
	task automatic send_item(logic [1:0] act, logic [4:0] nid, logic [4:0] row,
			logic [4:0] col);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 19) @(negedge clk);
		in_valid <= 1'b1;
		action <= act;
		node_id <= nid;
		query_row <= row;
		query_column <= col;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// wait for the block to drain, then write one register
	task automatic write_reg(logic [0:0] idx, logic [5:0] val);
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// a burst: six pushes, then three reads and a query
	task automatic mesh_burst(int n);
		for (int i = 0; i < 6; i++)
			send_item(eacsr_pkg::ACT_PUSH, 5'($urandom_range(n - 1)), 5'($urandom),
				5'($urandom));
		for (int i = 0; i < 3; i++)
			send_item(eacsr_pkg::ACT_READ, 5'($urandom), 5'($urandom_range(n - 1)),
				5'($urandom));
		send_item(eacsr_pkg::ACT_QUERY, 5'($urandom), 5'($urandom_range(n - 1)),
			5'($urandom_range(n - 1)));
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// directed: defaults, extremes, duplicates and errors
		send_item(eacsr_pkg::ACT_PUSH, 0, 0, 0);
		send_item(eacsr_pkg::ACT_PUSH, 31, 0, 0);
		send_item(eacsr_pkg::ACT_PUSH, 0, 0, 0);
		send_item(eacsr_pkg::ACT_PUSH, 17, 0, 0);
		send_item(eacsr_pkg::ACT_READ, 0, 0, 0);
		send_item(eacsr_pkg::ACT_READ, 0, 31, 0);
		send_item(eacsr_pkg::ACT_READ, 0, 5, 0);
		send_item(eacsr_pkg::ACT_QUERY, 0, 0, 31);
		send_item(eacsr_pkg::ACT_QUERY, 0, 31, 31);
		send_item(eacsr_pkg::ACT_CLEAR, 0, 0, 0);
		write_reg(eacsr_pkg::CFG_ELEMENT_SIZE, 6'd8);
		for (int i = 0; i < 8; i++) send_item(eacsr_pkg::ACT_PUSH, 5'(31 - i), 0, 0);
		send_item(eacsr_pkg::ACT_READ, 0, 31, 0);
		send_item(eacsr_pkg::ACT_READ, 0, 24, 0);
		write_reg(eacsr_pkg::CFG_NODE_COUNT, 6'd10);
		send_item(eacsr_pkg::ACT_READ, 0, 12, 0);
		send_item(eacsr_pkg::ACT_QUERY, 0, 3, 20);
		send_item(eacsr_pkg::ACT_PUSH, 20, 0, 0);
		send_item(eacsr_pkg::ACT_READ, 0, 0, 0);
		send_item(eacsr_pkg::ACT_CLEAR, 0, 0, 0);
		// out-of-range register values
		write_reg(eacsr_pkg::CFG_NODE_COUNT, 6'd0);
		send_item(eacsr_pkg::ACT_PUSH, 0, 0, 0);
		send_item(eacsr_pkg::ACT_CLEAR, 0, 0, 0);
		write_reg(eacsr_pkg::CFG_NODE_COUNT, 6'd63);
		write_reg(eacsr_pkg::CFG_ELEMENT_SIZE, 6'd0);
		send_item(eacsr_pkg::ACT_PUSH, 3, 0, 0);
		write_reg(eacsr_pkg::CFG_ELEMENT_SIZE, 6'd15);
		// random phases
		for (int ph = 0; ph < 12; ph++) begin
			calm = (ph == 5 || ph == 6);
			write_reg(eacsr_pkg::CFG_NODE_COUNT,
				(ph % 4 == 0) ? 6'd32 : 6'($urandom_range(1, 40)));
			write_reg(eacsr_pkg::CFG_ELEMENT_SIZE,
				(ph % 3 == 0) ? 6'd2 : 6'($urandom_range(0, 15)));
			for (int b = 0; b < 3; b++) mesh_burst(4 + $urandom_range(28));
			for (int i = 0; i < 2; i++)
				send_item(2'($urandom), 5'($urandom), 5'($urandom), 5'($urandom));
			if ($urandom_range(1)) send_item(eacsr_pkg::ACT_CLEAR, 0, 0, 0);
		end
		calm = 0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (fail_count == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end
endmodule
